>>> design/lsp_pkg.sv
// Shared types and constants for the LED strip pattern generator.
`default_nettype none

package lsp_pkg;

    typedef enum logic [1:0] {
        PAT_OFF     = 2'd0,
        PAT_RAINBOW = 2'd1,
        PAT_RUNNER  = 2'd2,
        PAT_BLINKER = 2'd3
    } pattern_t;

    typedef enum logic [1:0] {
        FRAME_BLACK   = 2'd0,
        FRAME_WHITE   = 2'd1,
        FRAME_RUNNER  = 2'd2,
        FRAME_RAINBOW = 2'd3
    } frame_kind_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_SET    = 1'b1;

    localparam logic [1:0] CFG_RAINBOW_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_TOGGLE_INTERVAL  = 2'd1;
    localparam logic [1:0] CFG_BLINK_TOGGLES    = 2'd2;

    localparam logic [15:0] RAINBOW_INTERVAL_RESET = 16'd8;
    localparam logic [15:0] TOGGLE_INTERVAL_RESET  = 16'd100;
    localparam logic [3:0]  BLINK_TOGGLES_RESET    = 4'd12;

    // The hue counter runs through five turns of the wheel.
    localparam logic [10:0] HUE_LAST = 11'd1279;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        frame_kind_t kind;
        logic        phase;
        logic [7:0]  hue;
    } frame_cmd_t;

    typedef struct packed {
        logic       first_valid;
        frame_cmd_t first;
        logic       second_valid;
        frame_cmd_t second;
    } frame_push_t;

endpackage

`default_nettype wire

>>> design/lsp_in_if.sv
// Input item channel: mode, time and pattern selection.
`default_nettype none

interface lsp_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] now_ms;
    logic [1:0]  new_pattern;

    modport source (output valid, output mode, output now_ms, output new_pattern,
                    input ready);
    modport sink   (input valid, input mode, input now_ms, input new_pattern,
                    output ready);
endinterface

`default_nettype wire

>>> design/lsp_pix_if.sv
// Pixel result channel.
`default_nettype none

interface lsp_pix_if;
    logic       valid;
    logic       ready;
    logic [4:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_in_frame;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output last_in_frame, input ready);
    modport sink   (input valid, input pixel_index, input red, input green,
                    input blue, input last_in_frame, output ready);
endinterface

`default_nettype wire

>>> design/lsp_cfg_if.sv
// Configuration write channel.
`default_nettype none

interface lsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/lsp_front.sv
// Front end: accepts items and configuration, keeps pattern state, issues frame commands.
`default_nettype none

module lsp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lsp_in_if.sink              item,
    lsp_cfg_if.sink             cfg,
    input  wire logic           room,
    output lsp_pkg::frame_push_t push
);
    import lsp_pkg::*;

    logic [15:0] rain_int_reg, rain_int_next;
    logic [15:0] tog_int_reg, tog_int_next;
    logic [3:0]  blink_tog_reg, blink_tog_next;
    pattern_t    pattern_reg, pattern_next;
    pattern_t    prev_reg, prev_next;
    logic [3:0]  blink_reg, blink_next;
    logic [10:0] hue_reg, hue_next;
    logic [31:0] last_ms_reg, last_ms_next;
    logic        phase_reg, phase_next;

    logic        accept;
    logic [31:0] elapsed;
    logic        rain_due;
    logic        tog_due;
    logic [3:0]  blink_inc;

    assign item.ready = room;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && room;

    always_comb
    begin
        rain_int_next  = rain_int_reg;
        tog_int_next   = tog_int_reg;
        blink_tog_next = blink_tog_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_RAINBOW_INTERVAL: rain_int_next  = cfg.data;
                CFG_TOGGLE_INTERVAL:  tog_int_next   = cfg.data;
                CFG_BLINK_TOGGLES:    blink_tog_next = cfg.data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pattern_next = pattern_reg;
        prev_next    = prev_reg;
        blink_next   = blink_reg;
        hue_next     = hue_reg;
        last_ms_next = last_ms_reg;
        phase_next   = phase_reg;
        push         = '0;
        elapsed      = item.now_ms - last_ms_reg;
        rain_due     = elapsed > {16'd0, rain_int_reg};
        tog_due      = elapsed > {16'd0, tog_int_reg};
        blink_inc    = blink_reg + 4'd1;

        if (accept)
        begin
            if (item.mode == MODE_SET)
            begin
                prev_next          = pattern_reg;
                pattern_next       = pattern_t'(item.new_pattern);
                blink_next         = 4'd0;
                hue_next           = 11'd0;
                last_ms_next       = 32'd0;
                push.first_valid   = 1'b1;
                push.first.kind    = FRAME_BLACK;
            end
            else
            begin
                case (pattern_reg)
                    PAT_RAINBOW:
                    begin
                        if (rain_due)
                        begin
                            last_ms_next     = item.now_ms;
                            push.first_valid = 1'b1;
                            push.first.kind  = FRAME_RAINBOW;
                            push.first.hue   = hue_reg[7:0];
                            hue_next = (hue_reg == HUE_LAST) ? 11'd0 : hue_reg + 11'd1;
                        end
                    end
                    PAT_RUNNER:
                    begin
                        if (tog_due)
                        begin
                            last_ms_next     = item.now_ms;
                            push.first_valid = 1'b1;
                            push.first.kind  = FRAME_RUNNER;
                            push.first.phase = phase_reg;
                            phase_next       = ~phase_reg;
                        end
                    end
                    PAT_BLINKER:
                    begin
                        if ((blink_reg < blink_tog_reg) && tog_due)
                        begin
                            last_ms_next     = item.now_ms;
                            push.first_valid = 1'b1;
                            push.first.kind  = phase_reg ? FRAME_BLACK : FRAME_WHITE;
                            phase_next       = ~phase_reg;
                            blink_next       = blink_inc;
                            // The final toggle restores the earlier pattern with a black frame.
                            if (blink_inc == blink_tog_reg)
                            begin
                                prev_next         = PAT_BLINKER;
                                pattern_next      = prev_reg;
                                blink_next        = 4'd0;
                                hue_next          = 11'd0;
                                last_ms_next      = 32'd0;
                                push.second_valid = 1'b1;
                                push.second.kind  = FRAME_BLACK;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rain_int_reg  <= RAINBOW_INTERVAL_RESET;
            tog_int_reg   <= TOGGLE_INTERVAL_RESET;
            blink_tog_reg <= BLINK_TOGGLES_RESET;
            pattern_reg   <= PAT_OFF;
            prev_reg      <= PAT_OFF;
            blink_reg     <= 4'd0;
            hue_reg       <= 11'd0;
            last_ms_reg   <= 32'd0;
            phase_reg     <= 1'b1;
        end
        else
        begin
            rain_int_reg  <= rain_int_next;
            tog_int_reg   <= tog_int_next;
            blink_tog_reg <= blink_tog_next;
            pattern_reg   <= pattern_next;
            prev_reg      <= prev_next;
            blink_reg     <= blink_next;
            hue_reg       <= hue_next;
            last_ms_reg   <= last_ms_next;
            phase_reg     <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> design/lsp_frame_queue.sv
// Short queue of frame commands between the front and back ends.
`default_nettype none

module lsp_frame_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lsp_pkg::frame_push_t push,
    output logic                     room,
    input  wire logic                pop,
    output lsp_pkg::frame_cmd_t      head,
    output logic                     nonempty
);
    import lsp_pkg::*;

    frame_cmd_t          entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QCNT_W-1:0]   push_cnt;

    // Room means space for the two frames that one item can cause.
    assign room     = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign nonempty = count_reg != '0;
    assign head     = entries[rd_ptr_reg];
    assign push_cnt = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_cnt - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            entries[wr_ptr_reg + QPTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> design/lsp_back.sv
// Back end: expands frame commands into pixels through an output register.
`default_nettype none

module lsp_back #(
    parameter int PIXEL_COUNT = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lsp_pkg::frame_cmd_t head,
    input  wire logic               nonempty,
    output logic                    pop,
    lsp_pix_if.source               pixel
);
    import lsp_pkg::*;

    localparam int         REM_W    = $clog2(PIXEL_COUNT) + 1;
    localparam int         STEP_Q   = 256 / PIXEL_COUNT;
    localparam int         STEP_R   = 256 % PIXEL_COUNT;
    localparam logic [4:0] LAST_IDX = 5'(PIXEL_COUNT - 1);

    back_state_t       state_reg, state_next;
    frame_cmd_t        cmd_reg, cmd_next;
    logic [4:0]        idx_reg, idx_next;
    logic [7:0]        quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;
    logic [4:0]        out_idx_reg;
    logic [7:0]        out_red_reg, out_green_reg, out_blue_reg;
    logic              out_last_reg;

    logic              advance;
    logic              last_pix;
    logic [REM_W-1:0]  rem_sum;
    logic [7:0]        wheel_pos;
    logic [7:0]        wheel_p;
    logic [7:0]        seg_q;
    logic [8:0]        seg_q3;
    logic [7:0]        tri_up;
    logic [7:0]        pix_red, pix_green, pix_blue;

    assign last_pix = idx_reg == LAST_IDX;

    // Output control.
    always_comb
    begin
        advance = 1'b0;
        pop     = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                pop = nonempty;
            end
            BACK_RUN:
            begin
                advance = !out_valid_reg || pixel.ready;
                pop     = advance && last_pix && nonempty;
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                if (nonempty)
                begin
                    state_next = BACK_RUN;
                end
            end
            BACK_RUN:
            begin
                if (advance && last_pix && !nonempty)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    // Pixel position i*256/PIXEL_COUNT is kept as a running quotient and remainder.
    always_comb
    begin
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        rem_sum  = rem_reg + REM_W'(STEP_R);
        if (pop)
        begin
            cmd_next = head;
            idx_next = 5'd0;
            quo_next = 8'd0;
            rem_next = '0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 5'd1;
            if (rem_sum >= REM_W'(PIXEL_COUNT))
            begin
                rem_next = rem_sum - REM_W'(PIXEL_COUNT);
                quo_next = quo_reg + 8'(STEP_Q) + 8'd1;
            end
            else
            begin
                rem_next = rem_sum;
                quo_next = quo_reg + 8'(STEP_Q);
            end
        end
    end

    // Color of the current pixel.
    always_comb
    begin
        wheel_pos = quo_reg + cmd_reg.hue;
        wheel_p   = ~wheel_pos;
        if (wheel_p < 8'd85)
        begin
            seg_q = wheel_p;
        end
        else if (wheel_p < 8'd170)
        begin
            seg_q = wheel_p - 8'd85;
        end
        else
        begin
            seg_q = wheel_p - 8'd170;
        end
        seg_q3 = {seg_q, 1'b0} + {1'b0, seg_q};
        tri_up = seg_q3[7:0];

        pix_red   = 8'd0;
        pix_green = 8'd0;
        pix_blue  = 8'd0;
        case (cmd_reg.kind)
            FRAME_WHITE:
            begin
                pix_red   = 8'd255;
                pix_green = 8'd255;
                pix_blue  = 8'd255;
            end
            FRAME_RUNNER:
            begin
                if (idx_reg[0] == cmd_reg.phase)
                begin
                    pix_blue = 8'd255;
                end
            end
            FRAME_RAINBOW:
            begin
                if (wheel_p < 8'd85)
                begin
                    pix_red  = 8'd255 - tri_up;
                    pix_blue = tri_up;
                end
                else if (wheel_p < 8'd170)
                begin
                    pix_green = tri_up;
                    pix_blue  = 8'd255 - tri_up;
                end
                else
                begin
                    pix_red   = tri_up;
                    pix_green = 8'd255 - tri_up;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        if (advance)
        begin
            out_idx_reg   <= idx_reg;
            out_red_reg   <= pix_red;
            out_green_reg <= pix_green;
            out_blue_reg  <= pix_blue;
            out_last_reg  <= last_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_index   = out_idx_reg;
    assign pixel.red           = out_red_reg;
    assign pixel.green         = out_green_reg;
    assign pixel.blue          = out_blue_reg;
    assign pixel.last_in_frame = out_last_reg;

endmodule

`default_nettype wire

>>> design/led_strip_pattern_generator.sv
// Top level of the LED strip pattern generator: front end, frame queue and pixel back end.
// An item causes zero, one or two frames of PIXEL_COUNT pixels; items are taken while the
// queue has room for two frames. The back end sends one pixel a cycle unless pixel.ready
// holds it off; frame commands go from the queue to the command register and pixels leave
// through the output register. Reset clears control state and restores the config registers.
`default_nettype none

module led_strip_pattern_generator #(
    parameter int PIXEL_COUNT = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lsp_in_if.sink    item,
    lsp_cfg_if.sink   cfg,
    lsp_pix_if.source pixel
);
    import lsp_pkg::*;

    frame_push_t push;
    frame_cmd_t  head;
    logic        room;
    logic        pop;
    logic        nonempty;

    lsp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    lsp_frame_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty)
    );

    lsp_back #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .nonempty (nonempty),
        .pop      (pop),
        .pixel    (pixel)
    );

endmodule

`default_nettype wire
